FILE: rtl/nand_page_read_sequencer_defines.svh
// assertion macros shared by the read sequencer modules
`ifndef NAND_PAGE_READ_SEQUENCER_DEFINES_SVH
`define NAND_PAGE_READ_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define NPRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define NPRS_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define NPRS_ASSERT(label, clk, rst, prop, msg)
`define NPRS_NEVER(label, clk, rst, cond, msg)

`endif

`endif

FILE: rtl/nprs_pkg.sv
`default_nettype none

package nprs_pkg;

   // page geometry
   localparam int PAGE_BYTES = 2048;
   localparam int COL_W      = $clog2(PAGE_BYTES);
   localparam int ROW_W      = 24;

   // request command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_READY = 2'd1;
   localparam logic [1:0] CMD_DATA  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_ADDR = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   // flash opcodes
   localparam logic [7:0] NAND_READ_SETUP = 8'h00;
   localparam logic [7:0] NAND_READ_START = 8'h30;

   // job queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // what follows the optional data beat of a job
   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_DONE,
      TAIL_BURST
   } tail_type;

   // one job from the front end to the back end
   typedef struct packed {
      logic             has_data;
      logic [7:0]       data_byte;
      logic [31:0]      dest_index;
      tail_type         tail;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
   } job_type;

endpackage

`default_nettype wire

FILE: rtl/nprs_front.sv
`default_nettype none

`include "nand_page_read_sequencer_defines.svh"

module nprs_front import nprs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_byte_addr,
   input  wire logic [31:0] req_length,
   input  wire logic [7:0]  req_device_byte,
   input  wire logic        q_full,
   output logic             q_push,
   output job_type          q_job
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_DATA
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [ROW_W-1:0] page_row_ff, page_row_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic [31:0]      bytes_done_ff, bytes_done_in;
   logic [31:0]      total_length_ff, total_length_in;
   logic             accept;
   logic [31:0]      bytes_next;

   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign bytes_next = bytes_done_ff + 32'd1;

   // classify the request and update the transfer state
   always_comb begin
      phase_in        = phase_ff;
      page_row_in     = page_row_ff;
      column_in       = column_ff;
      bytes_done_in   = bytes_done_ff;
      total_length_in = total_length_ff;
      q_push          = 1'b0;
      q_job           = '0;
      q_job.tail      = TAIL_NONE;
      if (accept) begin
         case (req_cmd)
            CMD_START: begin
               page_row_in     = ROW_W'(req_byte_addr >> COL_W);
               column_in       = req_byte_addr[COL_W-1:0];
               bytes_done_in   = '0;
               total_length_in = req_length;
               q_push          = 1'b1;
               q_job.column    = req_byte_addr[COL_W-1:0];
               q_job.row       = ROW_W'(req_byte_addr >> COL_W);
               if (req_length == '0) begin
                  phase_in   = PH_IDLE;
                  q_job.tail = TAIL_DONE;
               end else begin
                  phase_in   = PH_WAIT;
                  q_job.tail = TAIL_BURST;
               end
            end
            CMD_READY: begin
               if (phase_ff == PH_WAIT) begin
                  phase_in = PH_DATA;
               end
            end
            CMD_DATA: begin
               if (phase_ff == PH_DATA) begin
                  q_push           = 1'b1;
                  q_job.has_data   = 1'b1;
                  q_job.data_byte  = req_device_byte;
                  q_job.dest_index = bytes_done_ff;
                  bytes_done_in    = bytes_next;
                  column_in        = column_ff + 1'b1;
                  if (bytes_next == total_length_ff) begin
                     phase_in   = PH_IDLE;
                     q_job.tail = TAIL_DONE;
                  end else if (column_ff == COL_W'(PAGE_BYTES - 1)) begin
                     // page end: resend the command burst for the next row
                     page_row_in  = page_row_ff + 1'b1;
                     phase_in     = PH_WAIT;
                     q_job.tail   = TAIL_BURST;
                     q_job.column = '0;
                     q_job.row    = page_row_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         page_row_ff     <= '0;
         column_ff       <= '0;
         bytes_done_ff   <= '0;
         total_length_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         page_row_ff     <= page_row_in;
         column_ff       <= column_in;
         bytes_done_ff   <= bytes_done_in;
         total_length_ff <= total_length_in;
      end
   end

   `NPRS_ASSERT(a_data_below_length, clock, reset, phase_ff == PH_DATA |-> bytes_done_ff < total_length_ff, "streaming with length already reached")
   `NPRS_ASSERT(a_start_leaves_data, clock, reset, accept && req_cmd == CMD_START |=> phase_ff != PH_DATA, "start request left block streaming")

endmodule

`default_nettype wire

FILE: rtl/nprs_queue.sv
`default_nettype none

`include "nand_page_read_sequencer_defines.svh"

module nprs_queue import nprs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job
);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `NPRS_NEVER(a_push_when_full, clock, reset, push && full, "job pushed into full queue")
   `NPRS_NEVER(a_pop_when_empty, clock, reset, pop && !head_valid, "job popped from empty queue")

endmodule

`default_nettype wire

FILE: rtl/nprs_back.sv
`default_nettype none

`include "nand_page_read_sequencer_defines.svh"

module nprs_back import nprs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     head_valid,
   input  wire job_type  head_job,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output logic [1:0]    rsp_cycle_kind,
   output logic [7:0]    rsp_cycle_value,
   output logic [31:0]   rsp_dest_index,
   output logic          rsp_last_of_run
);

   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [7:0]  value_ff;
   logic [31:0] index_ff;
   logic        last_ff;
   logic        first_ff;
   logic [2:0]  step_ff;
   logic [2:0]  cur_step;
   logic [2:0]  last_step;
   logic        load;
   logic        is_last;
   logic [15:0] col16;
   logic [1:0]  beat_kind;
   logic [7:0]  beat_value;
   logic [31:0] beat_index;

   assign col16    = 16'(head_job.column);
   assign cur_step = first_ff ? (head_job.has_data ? 3'd0 : 3'd1) : step_ff;
   assign load     = head_valid && (!rsp_valid_ff || rsp_ready);
   assign is_last  = (cur_step == last_step);
   assign pop      = load && is_last;

   // final beat of the job
   always_comb begin
      case (head_job.tail)
         TAIL_DONE:  last_step = 3'd1;
         TAIL_BURST: last_step = 3'd7;
         default:    last_step = 3'd0;
      endcase
   end

   // beat for the current step
   always_comb begin
      beat_kind  = KIND_ADDR;
      beat_value = '0;
      beat_index = '0;
      if (cur_step == 3'd0) begin
         beat_kind  = KIND_DATA;
         beat_value = head_job.data_byte;
         beat_index = head_job.dest_index;
      end else if (head_job.tail == TAIL_DONE) begin
         beat_kind = KIND_DONE;
      end else begin
         case (cur_step)
            3'd1: begin
               beat_kind  = KIND_CMD;
               beat_value = NAND_READ_SETUP;
            end
            3'd2:    beat_value = col16[7:0];
            3'd3:    beat_value = col16[15:8];
            3'd4:    beat_value = head_job.row[7:0];
            3'd5:    beat_value = head_job.row[15:8];
            3'd6:    beat_value = head_job.row[23:16];
            default: begin
               beat_kind  = KIND_CMD;
               beat_value = NAND_READ_START;
            end
         endcase
      end
   end

   // step counter and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
         step_ff      <= '0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         first_ff     <= is_last;
         step_ff      <= cur_step + 3'd1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= beat_kind;
         value_ff <= beat_value;
         index_ff <= beat_index;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cycle_kind  = kind_ff;
   assign rsp_cycle_value = value_ff;
   assign rsp_dest_index  = index_ff;
   assign rsp_last_of_run = last_ff;

   `NPRS_ASSERT(a_done_is_last, clock, reset, rsp_valid_ff && kind_ff == KIND_DONE |-> last_ff, "done result not marked last")

endmodule

`default_nettype wire

FILE: rtl/nand_page_read_sequencer.sv
`default_nettype none

// Large-page NAND read sequencer. A start request (cmd 0) splits byte_addr into
// row and column and produces the read command burst: 0x00, two column bytes,
// three row bytes and 0x30; a ready event (cmd 1) then opens the data phase, and
// each data byte (cmd 2) comes back with its destination index. A page crossing
// resends the burst, and reaching the length ends with a done result. Requests
// are taken one per cycle while the job queue has room; results leave one per
// cycle while rsp_ready is high, so data bytes stream at full rate and a request
// that causes a command burst yields seven or eight results, which the four-entry
// job queue between the request decoder and the result sequencer absorbs.
module nand_page_read_sequencer import nprs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_byte_addr,
   input  wire logic [31:0] req_length,
   input  wire logic [7:0]  req_device_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_cycle_kind,
   output logic [7:0]       rsp_cycle_value,
   output logic [31:0]      rsp_dest_index,
   output logic             rsp_last_of_run
);

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_head_valid;
   job_type q_job;
   job_type q_head;

   // request decoder and transfer state
   nprs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_byte_addr   (req_byte_addr),
      .req_length      (req_length),
      .req_device_byte (req_device_byte),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (q_job)
   );

   // job queue
   nprs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_job   (q_head)
   );

   // result sequencer
   nprs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_job        (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cycle_kind  (rsp_cycle_kind),
      .rsp_cycle_value (rsp_cycle_value),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nprs_pkg::*;

   // command code with no meaning to the block
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int          RANDOM_ITEMS  = 220;
   localparam int          HOLD_CYCLES   = 400;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_WAIT,
      PHASE_DATA
   } read_phase_type;

   // one bus cycle as the result port shows it
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  value;
      logic [31:0] index;
      logic        last;
   } bus_cycle_type;

   // tracks the read sequence and holds the bus cycles still to come
   class read_scoreboard;
      read_phase_type phase;
      logic [23:0]    page_row;
      int unsigned    column;
      logic [31:0]    bytes_done;
      logic [31:0]    total_length;
      bus_cycle_type  pending_cycles[$];
      int             errors;
      int             requests;
      int             results;
      int             data_cycles;
      int             bursts;
      int             dones;

      function new();
         phase        = PHASE_IDLE;
         page_row     = '0;
         column       = 0;
         bytes_done   = '0;
         total_length = '0;
         errors       = 0;
         requests     = 0;
         results      = 0;
         data_cycles  = 0;
         bursts       = 0;
         dones        = 0;
      endfunction

      function void push_cycle(logic [1:0] kind, logic [7:0] value, logic [31:0] index);
         bus_cycle_type c;
         c.kind  = kind;
         c.value = value;
         c.index = index;
         c.last  = 1'b0;
         pending_cycles.push_back(c);
      endfunction

      // read command, column low/high, row low/mid/high, read start
      function void push_command_burst();
         push_cycle(KIND_CMD, NAND_READ_SETUP, '0);
         push_cycle(KIND_ADDR, 8'(column), '0);
         push_cycle(KIND_ADDR, 8'(column >> 8), '0);
         push_cycle(KIND_ADDR, page_row[7:0], '0);
         push_cycle(KIND_ADDR, page_row[15:8], '0);
         push_cycle(KIND_ADDR, page_row[23:16], '0);
         push_cycle(KIND_CMD, NAND_READ_START, '0);
         phase = PHASE_WAIT;
         bursts++;
      endfunction

      function void note_request(logic [1:0] cmd, logic [31:0] addr, logic [31:0] len,
                                 logic [7:0] dbyte);
         int first;
         first = pending_cycles.size();
         requests++;
         case (cmd)
            CMD_START: begin
               page_row     = 24'(addr / PAGE_BYTES);
               column       = addr % PAGE_BYTES;
               bytes_done   = '0;
               total_length = len;
               if (len == 0) begin
                  phase = PHASE_IDLE;
                  push_cycle(KIND_DONE, '0, '0);
               end else begin
                  push_command_burst();
               end
            end
            CMD_READY: begin
               if (phase == PHASE_WAIT) phase = PHASE_DATA;
            end
            CMD_DATA: begin
               if (phase == PHASE_DATA) begin
                  push_cycle(KIND_DATA, dbyte, bytes_done);
                  bytes_done = bytes_done + 32'd1;
                  column     = column + 1;
                  // done wins over the page crossing
                  if (bytes_done >= total_length) begin
                     phase = PHASE_IDLE;
                     push_cycle(KIND_DONE, '0, '0);
                  end else if (column >= PAGE_BYTES) begin
                     column   = 0;
                     page_row = 24'(page_row + 24'd1);
                     push_command_burst();
                  end
               end
            end
            default: begin
            end
         endcase
         if (pending_cycles.size() > first)
            pending_cycles[pending_cycles.size() - 1].last = 1'b1;
      endfunction

      function void report_field(string name, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: mismatch on %s: expected %0h actual %0h", $time, name, want, got);
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] value, logic [31:0] index,
                                 logic last);
         bus_cycle_type want;
         results++;
         if (pending_cycles.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none actual kind %0d value %0h",
                     $time, kind, value);
            return;
         end
         want = pending_cycles.pop_front();
         if (kind == KIND_DATA) data_cycles++;
         if (kind == KIND_DONE) dones++;
         if (kind !== want.kind) report_field("cycle_kind", 32'(want.kind), 32'(kind));
         if (value !== want.value) report_field("cycle_value", 32'(want.value), 32'(value));
         if (index !== want.index) report_field("dest_index", want.index, index);
         if (last !== want.last) report_field("last_of_run", 32'(want.last), 32'(last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_UNUSED;
   logic [31:0] req_byte_addr = '0;
   logic [31:0] req_length = '0;
   logic [7:0]  req_device_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_cycle_kind;
   logic [7:0]  rsp_cycle_value;
   logic [31:0] rsp_dest_index;
   logic        rsp_last_of_run;

   read_scoreboard sb = new();
   int unsigned    cycle_count = 0;
   int             random_items = 0;
   int             hold_request = 0;
   logic           no_idle = 1'b0;

   nand_page_read_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_byte_addr   (req_byte_addr),
      .req_length      (req_length),
      .req_device_byte (req_device_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cycle_kind  (rsp_cycle_kind),
      .rsp_cycle_value (rsp_cycle_value),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  sb.pending_cycles.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: check accepted results, stall at random or on a hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_cycle_kind, rsp_cycle_value, rsp_dest_index, rsp_last_of_run);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_request(input logic [1:0] cmd, input logic [31:0] addr,
                               input logic [31:0] len, input logic [7:0] dbyte);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_byte_addr   <= addr;
      req_length      <= len;
      req_device_byte <= dbyte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, addr, len, dbyte);
   endtask

   // stop offering and let every expected result come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_cycles.size() != 0) @(posedge clock);
   endtask

   // ready event, data byte or unknown command sent out of phase
   task automatic send_noise();
      logic [1:0] cmd;
      if ($urandom_range(0, 3) == 0) cmd = CMD_UNUSED;
      else if (sb.phase == PHASE_DATA) cmd = CMD_READY;
      else cmd = CMD_DATA;
      send_request(cmd, $urandom, $urandom, 8'($urandom));
   endtask

   // one read: start, then ready events and data bytes as the sequence calls for
   task automatic run_random_read();
      logic [31:0] col;
      logic [31:0] addr;
      logic [31:0] len;
      int          r;
      int          steps;
      int          max_steps;
      if ($urandom_range(0, 9) < 7) col = 32'(PAGE_BYTES - $urandom_range(1, 16));
      else col = 32'($urandom_range(0, PAGE_BYTES - 1));
      addr = ($urandom & ~32'(PAGE_BYTES - 1)) | col;
      r = $urandom_range(0, 99);
      if (r < 10) len = '0;
      else if (r < 80) len = 32'($urandom_range(1, 24));
      else if (r < 90) len = 32'($urandom_range(25, 60));
      else len = $urandom;
      send_request(CMD_START, addr, len, 8'($urandom));
      random_items++;
      max_steps = $urandom_range(20, 70);
      steps = 0;
      while (sb.phase != PHASE_IDLE && steps < max_steps) begin
         r = $urandom_range(0, 99);
         steps++;
         // leave the transfer open so the next start aborts it
         if (r < 3) break;
         if (r < 11) begin
            send_noise();
         end else begin
            if (sb.phase == PHASE_WAIT)
               send_request(CMD_READY, $urandom, $urandom, 8'($urandom));
            else
               send_request(CMD_DATA, $urandom, $urandom, 8'($urandom));
            random_items++;
         end
      end
   endtask

   initial begin
      int mark;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zero length, then out-of-phase and unknown requests while idle
      send_request(CMD_START, 32'h0, 32'h0, 8'h00);
      send_request(CMD_READY, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
      send_request(CMD_DATA, 32'h0, 32'h0, 8'h5a);
      send_request(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 8'hff);

      // top address: last column, page crossing, extra ready while streaming
      send_request(CMD_START, 32'hffff_ffff, 32'd2, 8'h00);
      send_request(CMD_DATA, 32'h0, 32'h0, 8'h11);
      send_request(CMD_READY, 32'h0, 32'h0, 8'h00);
      send_request(CMD_READY, 32'h0, 32'h0, 8'h00);
      send_request(CMD_DATA, 32'h0, 32'h0, 8'hff);
      send_request(CMD_READY, 32'h0, 32'h0, 8'h00);
      send_request(CMD_DATA, 32'h0, 32'h0, 8'h00);

      // last byte of the request is also the last of the page
      send_request(CMD_START, 32'h0000_07fe, 32'd2, 8'h00);
      send_request(CMD_READY, 32'h0, 32'h0, 8'h00);
      send_request(CMD_DATA, 32'h0, 32'h0, 8'ha5);
      send_request(CMD_DATA, 32'h0, 32'h0, 8'h3c);

      // maximal length, aborted by a new start
      send_request(CMD_START, 32'h1234_5678, 32'hffff_ffff, 8'h00);
      send_request(CMD_READY, 32'h0, 32'h0, 8'h00);
      send_request(CMD_DATA, 32'h0, 32'h0, 8'h00);
      send_request(CMD_UNUSED, 32'h0, 32'h0, 8'h00);
      send_request(CMD_DATA, 32'h0, 32'h0, 8'hff);
      send_request(CMD_START, 32'h0000_0800, 32'h0, 8'h00);

      // random reads with idling on both sides
      while (random_items < RANDOM_ITEMS / 2) run_random_read();

      // long result stall while requests keep coming at full rate
      no_idle = 1'b1;
      hold_request = HOLD_CYCLES;
      mark = random_items;
      while (random_items < mark + 30) run_random_read();
      no_idle = 1'b0;
      wait_for_drain();

      // rest of the random reads, some stretches without idling
      while (random_items < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 5) == 0);
         run_random_read();
      end
      no_idle = 1'b0;

      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("%0d requests sent, %0d results checked: %0d data bytes, %0d command bursts,",
               sb.requests, sb.results, sb.data_cycles, sb.bursts);
      $display("%0d done results, %0d mismatches", sb.dones, sb.errors);
      if (sb.errors == 0 && sb.pending_cycles.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
